### hw/rtl/clts_pkg.sv
// Shared constants, types and a helper function for the color table sample unit.
package clts_pkg;

    localparam int TABLE_DEPTH_DEF = 8192;
    localparam int GRID_MAX_DEF    = 17;

    localparam int VAL_W   = 16;
    localparam int SCALE_W = 24;
    localparam int GRID_W  = 14;
    localparam int IDX_W   = 13;
    localparam int FRAC_W  = 12;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [2:0] REG_RED_MIN     = 3'd0;
    localparam logic [2:0] REG_GREEN_MIN   = 3'd1;
    localparam logic [2:0] REG_BLUE_MIN    = 3'd2;
    localparam logic [2:0] REG_RED_SCALE   = 3'd3;
    localparam logic [2:0] REG_GREEN_SCALE = 3'd4;
    localparam logic [2:0] REG_BLUE_SCALE  = 3'd5;
    localparam logic [2:0] REG_GRID_SIZE   = 3'd6;
    localparam logic [2:0] REG_CUBE_MODE   = 3'd7;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [FRAC_W-1:0] frac_t;

    // Rounded linear blend a*(1-t) + b*t with t in Q0.12.
    function automatic val_t blend(input val_t a, input val_t b, input frac_t t);
        logic signed [31:0] s;
        begin
            s = 32'(a) * $signed({1'b0, 13'd4096 - {1'b0, t}})
              + 32'(b) * $signed({1'b0, 1'b0, t}) + 32'sd2048;
            blend = s[27:12];
        end
    endfunction

endpackage

### hw/rtl/clts_table.sv
// Table memory with eight read ports, made of one replicated copy per read port.
module clts_table #(
    parameter int DEPTH = clts_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [47:0]        wr_data,
    input  logic               rd_en,
    input  logic [8*AW-1:0]    rd_addr,
    output logic [8*48-1:0]    rd_data
);

    for (genvar p = 0; p < 8; p++)
    begin : g_copy
        logic [47:0] mem [DEPTH];
        logic [47:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                q_reg <= mem[rd_addr[p*AW +: AW]];
            end
        end

        assign rd_data[p*48 +: 48] = q_reg;
    end

endmodule

### hw/rtl/color_lut_trilinear_sample_unit.sv
// Each accepted sample word gives one result word; loads give no word.
// Throughput: one word per cycle; the whole pipeline holds while a result waits at the
// output register and moves again in the cycle that result is taken.
// Reset clears valid bits and configuration registers; the table content is undefined
// until loaded and is never cleared.
module color_lut_trilinear_sample_unit #(
    parameter int TABLE_DEPTH = clts_pkg::TABLE_DEPTH_DEF,
    parameter int GRID_MAX    = clts_pkg::GRID_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // entry_index[12:0], red[28:13], green[44:29], blue[60:45]
    input  logic        s_tuser,  // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // out_red[15:0], out_green[31:16], out_blue[47:32]
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NS = 8;

    // Configuration.
    logic signed [15:0] min_reg [3];
    logic [23:0] scale_reg [3];
    logic [13:0] grid_reg;
    logic        cube_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                min_reg[c]   <= '0;
                scale_reg[c] <= 24'd256;
            end
            grid_reg <= 14'd2;
            cube_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                clts_pkg::REG_RED_MIN:     min_reg[0]   <= cfg_data[15:0];
                clts_pkg::REG_GREEN_MIN:   min_reg[1]   <= cfg_data[15:0];
                clts_pkg::REG_BLUE_MIN:    min_reg[2]   <= cfg_data[15:0];
                clts_pkg::REG_RED_SCALE:   scale_reg[0] <= cfg_data;
                clts_pkg::REG_GREEN_SCALE: scale_reg[1] <= cfg_data;
                clts_pkg::REG_BLUE_SCALE:  scale_reg[2] <= cfg_data;
                clts_pkg::REG_GRID_SIZE:   grid_reg     <= cfg_data[13:0];
                clts_pkg::REG_CUBE_MODE:   cube_reg     <= cfg_data[0];
                default:                   cube_reg     <= cube_reg;
            endcase
        end
    end

    // Effective size; the user must keep it constant while items flow, as the block does not enforce it.
    logic [16:0] n_eff;
    always_comb
    begin
        n_eff = (grid_reg < 14'd1) ? 17'd1 : {3'd0, grid_reg};
        if (cube_reg)
        begin
            if (n_eff > 17'(GRID_MAX))
                n_eff = 17'(GRID_MAX);
        end
        else if (n_eff > 17'(TABLE_DEPTH))
        begin
            n_eff = 17'(TABLE_DEPTH);
        end
    end
    logic [16:0] nm1;
    assign nm1 = n_eff - 17'd1;

    // Pipeline: the whole pipe advances when the output stage is free.
    logic adv;
    logic [NS-1:0] vld_reg;
    logic out_vld_reg;
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;

    logic s_acc;
    assign s_acc = s_tvalid && adv;

    logic load_acc;
    assign load_acc = s_acc && (s_tuser == clts_pkg::FUNC_LOAD)
                    && (32'(s_tdata[12:0]) < 32'(TABLE_DEPTH));

    // Loads reach the table at the stage where samples read it, so every sample
    // sees exactly the loads that came before it.
    logic [4:0]    ld_vld_reg;
    logic [AW-1:0] ld_addr_reg [5];
    logic [47:0]   ld_data_reg [5];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ld_addr_reg[0] <= AW'(s_tdata[12:0]);
            ld_data_reg[0] <= s_tdata[60:13];
            for (int i = 1; i < 5; i++)
            begin
                ld_addr_reg[i] <= ld_addr_reg[i-1];
                ld_data_reg[i] <= ld_data_reg[i-1];
            end
        end
    end

    // Stage 1: offsets; loads enter the write delay line.
    logic signed [16:0] d1_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                d1_reg[c] <= 17'($signed(s_tdata[13+16*c +: 16])) - 17'(min_reg[c]);
            end
        end
    end

    // Stage 2: position product.
    logic [40:0] pos2_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pos2_reg[c] <= (d1_reg[c] > 0) ? 41'(d1_reg[c][15:0]) * 41'(scale_reg[c]) : '0;
            end
        end
    end

    // Stage 3: clamp and split.
    logic [16:0] lo3_reg [3];
    logic [16:0] hi3_reg [3];
    clts_pkg::frac_t t3_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (pos2_reg[c] > {4'd0, nm1, 20'd0})
                begin
                    lo3_reg[c] <= nm1;
                    t3_reg[c]  <= '0;
                    hi3_reg[c] <= nm1;
                end
                else
                begin
                    lo3_reg[c] <= pos2_reg[c][36:20];
                    t3_reg[c]  <= pos2_reg[c][19:8];
                    hi3_reg[c] <= (pos2_reg[c][36:20] + 17'd1 < n_eff) ?
                                  pos2_reg[c][36:20] + 17'd1 : nm1;
                end
            end
        end
    end

    // Stage 4: partial products of corner addresses (b*n, g).
    logic [33:0] bn4_reg [2];
    logic [16:0] g4_reg [2];
    logic [16:0] r4_reg [2];
    logic [16:0] l4_reg [3];
    logic [16:0] h4_reg [3];
    clts_pkg::frac_t t4_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bn4_reg[0] <= 34'(lo3_reg[2]) * 34'(n_eff);
            bn4_reg[1] <= 34'(hi3_reg[2]) * 34'(n_eff);
            g4_reg[0] <= lo3_reg[1];
            g4_reg[1] <= hi3_reg[1];
            r4_reg[0] <= lo3_reg[0];
            r4_reg[1] <= hi3_reg[0];
            l4_reg <= lo3_reg;
            h4_reg <= hi3_reg;
            t4_reg <= t3_reg;
        end
    end

    // Stage 5: (b*n + g) * n.
    logic [40:0] bg5_reg [4];
    logic [16:0] r5_reg [2];
    logic [16:0] l5_reg [3];
    logic [16:0] h5_reg [3];
    clts_pkg::frac_t t5_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 2; k++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    bg5_reg[k*2+j] <= 41'(bn4_reg[k][23:0] + 24'(g4_reg[j])) * 41'(n_eff);
                end
            end
            r5_reg <= r4_reg;
            l5_reg <= l4_reg;
            h5_reg <= h4_reg;
            t5_reg <= t4_reg;
        end
    end

    // Stage 6: final addresses and table read request.
    logic [40:0] addr6 [8];
    logic [7:0]  oor6;
    logic [8*AW-1:0] rd_addr;
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    addr6[k*4+j*2+i] = bg5_reg[k*2+j] + 41'(r5_reg[i]);
                end
            end
        end
        if (!cube_reg)
        begin
            // One-dimensional mode: ports 0/1 serve red, 2/3 green, 4/5 blue.
            for (int c = 0; c < 3; c++)
            begin
                addr6[2*c]   = 41'(l5_reg[c]);
                addr6[2*c+1] = 41'(h5_reg[c]);
            end
        end
        for (int p = 0; p < 8; p++)
        begin
            oor6[p] = addr6[p] >= 41'(TABLE_DEPTH);
            rd_addr[p*AW +: AW] = addr6[p][AW-1:0];
        end
    end

    logic [7:0] oor7_reg;
    clts_pkg::frac_t t7_reg [3];
    clts_pkg::frac_t t8_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oor7_reg <= oor6;
            t7_reg   <= t5_reg;
        end
    end

    logic load_we;
    assign load_we = adv && ld_vld_reg[4];

    logic [8*48-1:0] rd_data;
    clts_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (ld_addr_reg[4]),
        .wr_data (ld_data_reg[4]),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Stage 7 is the registered read; stage 8 blends along red (or 1D blend).
    clts_pkg::val_t e7 [8][3];
    always_comb
    begin
        for (int p = 0; p < 8; p++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                e7[p][c] = oor7_reg[p] ? '0 : rd_data[p*48+16*c +: 16];
            end
        end
    end

    clts_pkg::val_t g8_reg [4][3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                g8_reg[0][c] <= cube_reg ?
                    clts_pkg::blend(e7[0][c], e7[1][c], t7_reg[0]) :
                    clts_pkg::blend(e7[2*c][c], e7[2*c+1][c], t7_reg[c]);
                for (int q = 1; q < 4; q++)
                begin
                    g8_reg[q][c] <= clts_pkg::blend(e7[2*q][c], e7[2*q+1][c], t7_reg[0]);
                end
            end
            t8_reg <= t7_reg;
        end
    end

    // Stage 9: blend along green; output register blends along blue, or passes the 1D result.
    clts_pkg::val_t b9_reg [2][3];
    clts_pkg::val_t one9_reg [3];
    clts_pkg::frac_t tb9_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                b9_reg[0][c] <= clts_pkg::blend(g8_reg[0][c], g8_reg[1][c], t8_reg[1]);
                b9_reg[1][c] <= clts_pkg::blend(g8_reg[2][c], g8_reg[3][c], t8_reg[1]);
                one9_reg[c]  <= g8_reg[0][c];
            end
            tb9_reg <= t8_reg[2];
        end
    end

    logic [47:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_reg[16*c +: 16] <= cube_reg ?
                    clts_pkg::blend(b9_reg[0][c], b9_reg[1][c], tb9_reg) : one9_reg[c];
            end
        end
    end
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            ld_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NS-2:0], s_acc && (s_tuser == clts_pkg::FUNC_SAMPLE)};
            ld_vld_reg  <= {ld_vld_reg[3:0], load_acc};
            out_vld_reg <= vld_reg[NS-1];
        end
    end

endmodule

### verif/tb.sv
// Testbench for the color table sample unit: random 1D and 3D lookups checked against a predictor.
`timescale 1ns / 100ps

module tb;

    typedef clts_pkg::val_t val_t;

    typedef struct {
        logic       func;
        logic [12:0] idx;
        val_t       r;
        val_t       g;
        val_t       b;
    } pixel_word_t;

    typedef struct {
        val_t r;
        val_t g;
        val_t b;
    } color_t;

    localparam int DEPTH    = clts_pkg::TABLE_DEPTH_DEF;
    localparam int GRID_CAP = clts_pkg::GRID_MAX_DEF;
    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    color_lut_trilinear_sample_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 clk = ~clk;

    pixel_word_t pending_words[$];
    color_t      expected_colors[$];
    int          error_count = 0;
    int          word_count = 0;
    bit          quiet = 1'b0;

    // Shadow of the block's table and registers.
    val_t        lut_mem[DEPTH][3];
    bit          loaded[DEPTH];
    val_t        dom_min[3];
    logic [23:0] dom_scale[3];
    logic [13:0] grid_reg;
    logic        cube_reg;

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic val_t mix(input val_t a, input val_t b, input logic [11:0] t);
        longint s;
        s = longint'(a) * (4096 - longint'(t)) + longint'(b) * longint'(t) + 2048;
        return val_t'(s >>> 12);
    endfunction

    task automatic push_load(input logic [12:0] idx, input val_t r, input val_t g,
                             input val_t b);
        pixel_word_t w;
        w.func = clts_pkg::FUNC_LOAD; w.idx = idx; w.r = r; w.g = g; w.b = b;
        pending_words = {pending_words, w};
        word_count++;
        lut_mem[idx][0] = r; lut_mem[idx][1] = g; lut_mem[idx][2] = b;
        loaded[idx] = 1'b1;
    endtask

    // Loads random content into an entry before a sample could read it unwritten.
    task automatic fill_entry(input int addr);
        if (!loaded[addr])
            push_load(13'(addr), val_t'($urandom), val_t'($urandom), val_t'($urandom));
    endtask

    task automatic push_sample(input val_t r, input val_t g, input val_t b);
        val_t        v[3];
        int          n, d, a;
        int          lo[3], hi[3];
        logic [11:0] t[3];
        longint      pos, maxpos;
        val_t        res[3];
        val_t        e[2][2][2];
        val_t        g0, g1, b0, b1;
        int          rr[2], gg[2], bb[2];
        pixel_word_t w;
        color_t      c;
        v[0] = r; v[1] = g; v[2] = b;
        n = (grid_reg < 1) ? 1 : int'(grid_reg);
        if (cube_reg && n > GRID_CAP)
            n = GRID_CAP;
        else if (!cube_reg && n > DEPTH)
            n = DEPTH;
        maxpos = longint'(n - 1) << 20;
        for (int ch = 0; ch < 3; ch++)
        begin
            d = int'(v[ch]) - int'(dom_min[ch]);
            pos = (d > 0) ? longint'(d) * longint'(dom_scale[ch]) : 0;
            if (pos > maxpos)
                pos = maxpos;
            lo[ch] = int'(pos >> 20);
            t[ch] = pos[19:8];
            hi[ch] = (lo[ch] + 1 < n) ? lo[ch] + 1 : n - 1;
        end
        rr[0] = lo[0]; rr[1] = hi[0];
        gg[0] = lo[1]; gg[1] = hi[1];
        bb[0] = lo[2]; bb[1] = hi[2];
        if (!cube_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                fill_entry(lo[ch]);
                fill_entry(hi[ch]);
            end
        end
        else
        begin
            for (int k = 0; k < 2; k++)
                for (int j = 0; j < 2; j++)
                    for (int i = 0; i < 2; i++)
                        fill_entry((bb[k] * n + gg[j]) * n + rr[i]);
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (!cube_reg)
                res[ch] = mix(lut_mem[lo[ch]][ch], lut_mem[hi[ch]][ch], t[ch]);
            else
            begin
                for (int k = 0; k < 2; k++)
                    for (int j = 0; j < 2; j++)
                        for (int i = 0; i < 2; i++)
                        begin
                            a = (bb[k] * n + gg[j]) * n + rr[i];
                            e[k][j][i] = lut_mem[a][ch];
                        end
                g0 = mix(e[0][0][0], e[0][0][1], t[0]);
                g1 = mix(e[0][1][0], e[0][1][1], t[0]);
                b0 = mix(g0, g1, t[1]);
                g0 = mix(e[1][0][0], e[1][0][1], t[0]);
                g1 = mix(e[1][1][0], e[1][1][1], t[0]);
                b1 = mix(g0, g1, t[1]);
                res[ch] = mix(b0, b1, t[2]);
            end
        end
        w.func = clts_pkg::FUNC_SAMPLE; w.idx = 13'($urandom); w.r = r; w.g = g; w.b = b;
        pending_words = {pending_words, w};
        word_count++;
        c.r = res[0]; c.g = res[1]; c.b = res[2];
        expected_colors = {expected_colors, c};
    endtask

    // Waits until every word is taken and every result has come, then lets loads drain.
    task automatic drain();
        wait (pending_words.size() == 0 && !s_tvalid && expected_colors.size() == 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input val_t rmin, input val_t gmin, input val_t bmin,
                                input logic [23:0] rs, input logic [23:0] gs,
                                input logic [23:0] bs, input logic [13:0] grid,
                                input logic cube);
        write_reg(clts_pkg::REG_RED_MIN, 24'(rmin));
        write_reg(clts_pkg::REG_GREEN_MIN, 24'(gmin));
        write_reg(clts_pkg::REG_BLUE_MIN, 24'(bmin));
        write_reg(clts_pkg::REG_RED_SCALE, rs);
        write_reg(clts_pkg::REG_GREEN_SCALE, gs);
        write_reg(clts_pkg::REG_BLUE_SCALE, bs);
        write_reg(clts_pkg::REG_GRID_SIZE, 24'(grid));
        write_reg(clts_pkg::REG_CUBE_MODE, 24'(cube));
        dom_min[0] = rmin; dom_min[1] = gmin; dom_min[2] = bmin;
        dom_scale[0] = rs; dom_scale[1] = gs; dom_scale[2] = bs;
        grid_reg = grid;
        cube_reg = cube;
    endtask

    function automatic val_t pick_value(input int ch);
        case ($urandom_range(0, 7))
            0: return val_t'(16'sh7fff);
            1: return val_t'(16'sh8000);
            2: return dom_min[ch];
            3: return val_t'(dom_min[ch] + 1);
            default: return val_t'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_scale(input bit capped);
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return capped ? 24'd4096 : 24'hffffff;
            2: return 24'(256);
            default: return 24'($urandom_range(0, capped ? 4096 : 2048));
        endcase
    endfunction

    // Stimulus and phase sequencing.
    initial
    begin
        logic        cube;
        logic [13:0] grid;
        val_t        m[3];
        int          phase_start;
        dom_min[0] = 0; dom_min[1] = 0; dom_min[2] = 0;
        dom_scale[0] = 24'd256; dom_scale[1] = 24'd256; dom_scale[2] = 24'd256;
        grid_reg = 14'd2;
        cube_reg = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at reset settings, with the table's top address loaded too.
        push_load(13'h1fff, val_t'(16'sh7fff), val_t'(16'sh8000), val_t'(16'sh0000));
        push_sample(val_t'(16'sh7fff), val_t'(16'sh8000), val_t'(0));
        push_sample(val_t'(0), val_t'(0), val_t'(0));
        push_sample(val_t'(-1), val_t'(1), val_t'(4096));
        push_sample(val_t'(2048), val_t'(4095), val_t'(4097));
        push_load(13'd0, val_t'(16'sh8000), val_t'(16'sh8000), val_t'(16'sh8000));
        push_load(13'd1, val_t'(16'sh7fff), val_t'(16'sh7fff), val_t'(16'sh7fff));
        for (int i = 0; i < 6; i++)
            push_sample(val_t'($urandom_range(0, 4096)), val_t'($urandom),
                        val_t'(16'sh7fff));
        drain();

        // Grid size zero in a cube: every read falls on entry 0.
        apply_config(val_t'(16'sh8000), val_t'(16'sh8000), val_t'(16'sh8000),
                     24'hffffff, 24'hffffff, 24'hffffff, 14'd0, 1'b1);
        for (int i = 0; i < 4; i++)
            push_sample(pick_value(0), pick_value(1), pick_value(2));
        drain();
        // Oversized grid saturates in a cube; largest minimum.
        apply_config(val_t'(16'sh7fff), val_t'(0), val_t'(16'sh8000),
                     24'hffffff, 24'd0, 24'd256, 14'h3fff, 1'b1);
        for (int i = 0; i < 6; i++)
            push_sample(pick_value(0), pick_value(1), pick_value(2));
        drain();
        // Largest 1D table with tiny scales.
        apply_config(val_t'(0), val_t'(16'sh8000), val_t'(-1),
                     24'd1, 24'd0, 24'd4096, 14'h3fff, 1'b0);
        for (int i = 0; i < 6; i++)
            push_sample(pick_value(0), pick_value(1), pick_value(2));
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            cube = 1'($urandom);
            case ($urandom_range(0, 5))
                0: grid = 14'($urandom_range(0, 3));
                1: grid = 14'(GRID_CAP);
                2: grid = 14'($urandom_range(18, 16383));
                default: grid = 14'($urandom_range(2, 17));
            endcase
            for (int ch = 0; ch < 3; ch++)
                m[ch] = ($urandom_range(0, 2) == 0) ? val_t'($urandom) : val_t'(16'sh8000);
            apply_config(m[0], m[1], m[2],
                         pick_scale(!cube && grid > 64), pick_scale(!cube && grid > 64),
                         pick_scale(!cube && grid > 64), grid, cube);
            if (phase == 10)
                quiet = 1'b1;
            // Each phase sends at least 145 words, fill loads included.
            phase_start = word_count;
            while (word_count - phase_start < 145)
            begin
                if ($urandom_range(0, 19) == 0)
                    push_load(13'($urandom), val_t'($urandom), val_t'($urandom),
                              val_t'($urandom));
                push_sample(pick_value(0), pick_value(1), pick_value(2));
            end
            drain();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Input driver.
    int send_gap = 0;
    always @(posedge clk)
    begin
        pixel_word_t w;
        if (rst_n && !(s_tvalid && !s_tready))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                w = pending_words.pop_front();
                s_tdata <= {3'b0, w.b, w.g, w.r, w.idx};
                s_tuser <= w.func;
                s_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 11);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result monitor with random output stalls.
    int stall_left = 0;
    always @(posedge clk)
    begin
        color_t c;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_colors.size() == 0)
                    report($sformatf("unexpected word %h", m_tdata));
                else
                begin
                    c = expected_colors.pop_front();
                    if (m_tdata[15:0] !== c.r)
                        report($sformatf("out_red %h, want %h", m_tdata[15:0], c.r));
                    if (m_tdata[31:16] !== c.g)
                        report($sformatf("out_green %h, want %h", m_tdata[31:16], c.g));
                    if (m_tdata[47:32] !== c.b)
                        report($sformatf("out_blue %h, want %h", m_tdata[47:32], c.b));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no word is accepted or taken.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
